// ===== hdl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the PWM compare clamp block
// Field widths, the per-phase clamp result and the statistics record.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int unsigned IO_PHASES = 3;
  localparam int unsigned REQ_W     = 32;
  localparam int unsigned CMP_W     = 16;
  localparam int unsigned CNT_W     = 32;

  localparam logic [CMP_W-1:0] RELOAD_RST = 16'hFFFF;

  typedef struct packed {
    logic [CMP_W-1:0] applied;
    logic             clamped;
  } pcc_phase_t;

  typedef struct packed {
    logic [REQ_W-1:0]                peak_req;
    logic [REQ_W-1:0]                min_req;
    logic [CMP_W-1:0]                peak_out;
    logic [CMP_W-1:0]                min_out;
    logic [CNT_W-1:0]                clamped_items;
    logic [IO_PHASES-1:0][CNT_W-1:0] clamps;
  } pcc_stats_t;

endpackage

`default_nettype wire

// ===== hdl/pcc_clamp.sv =====
// ----------------------------------------------------------------------------
// pcc_clamp: clamp one signed compare request to the range 0 .. reload
// Flags the phase as clamped when the request was below zero or above reload.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_clamp
  import pcc_pkg::*;
(
  input  logic [REQ_W-1:0] req_i,
  input  logic [CMP_W-1:0] reload_i,
  output pcc_phase_t       res_o
);

  logic neg;
  logic over;

  assign neg  = req_i[REQ_W-1];
  // magnitude compare on the non-negative range only
  assign over = !neg && (req_i[REQ_W-2:0] > {{(REQ_W-1-CMP_W){1'b0}}, reload_i});

  always_comb begin
    res_o.clamped = neg || over;
    if (neg) begin
      res_o.applied = '0;
    end else if (over) begin
      res_o.applied = reload_i;
    end else begin
      res_o.applied = req_i[CMP_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pcc_stats.sv =====
// ----------------------------------------------------------------------------
// pcc_stats: running extremes and saturating clamp counters
// Holds the statistics state and presents the values after the current beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_stats
  import pcc_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic [IO_PHASES-1:0]            phase_en_i,
  input  logic [IO_PHASES-1:0][REQ_W-1:0] req_i,
  input  pcc_phase_t [IO_PHASES-1:0]      res_i,
  output pcc_stats_t                      stats_o
);

  pcc_stats_t stats_q, stats_d;
  logic       any_seen_q, any_seen_d;
  logic       seed;
  logic       any_clamp;

  always_comb begin
    stats_d = stats_q;
    seed    = !any_seen_q;
    // phases in order; the first one after reset seeds all extremes
    for (int i = 0; i < IO_PHASES; i++) begin
      if (phase_en_i[i]) begin
        if (seed || ($signed(req_i[i]) > $signed(stats_d.peak_req))) begin
          stats_d.peak_req = req_i[i];
        end
        if (seed || ($signed(req_i[i]) < $signed(stats_d.min_req))) begin
          stats_d.min_req = req_i[i];
        end
        if (seed || (res_i[i].applied > stats_d.peak_out)) begin
          stats_d.peak_out = res_i[i].applied;
        end
        if (seed || (res_i[i].applied < stats_d.min_out)) begin
          stats_d.min_out = res_i[i].applied;
        end
        if (res_i[i].clamped && (stats_q.clamps[i] != '1)) begin
          stats_d.clamps[i] = stats_q.clamps[i] + CNT_W'(1);
        end
        seed = 1'b0;
      end
    end
    any_clamp = 1'b0;
    for (int i = 0; i < IO_PHASES; i++) begin
      any_clamp = any_clamp | (phase_en_i[i] & res_i[i].clamped);
    end
    if (any_clamp && (stats_q.clamped_items != '1)) begin
      stats_d.clamped_items = stats_q.clamped_items + CNT_W'(1);
    end
    any_seen_d = any_seen_q | (|phase_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q    <= '0;
      any_seen_q <= 1'b0;
    end else if (adv_i) begin
      stats_q    <= stats_d;
      any_seen_q <= any_seen_d;
    end
  end

  assign stats_o = stats_d;

endmodule

`default_nettype wire

// ===== hdl/pwm_compare_clamp_stats_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_compare_clamp_stats_unit: three-phase PWM compare clamp with statistics
// Clamps each requested compare to 0 .. reload and reports running stats.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid_i / in_stall_o, req_*   | three signed requests
//  out     | out_valid_o / out_stall_i, out_* | compares, mask, statistics
//  cfg     | cfg_we_i, cfg_wdata_i            | reload value, no read-back
//
//  One beat per cycle while out_stall_i does not hold the result; a beat
//  passes the input register, then clamp and statistics update into the result register.
//  Reset clears the statistics and sets reload to 16'hFFFF.
//  An out stall holds the result; the input register keeps accepting
//  until it is full, then in_stall_o follows out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_compare_clamp_stats_unit
  import pcc_pkg::*;
#(
  parameter int unsigned PHASES = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CMP_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [REQ_W-1:0] req_phase_a_i,
  input  logic signed [REQ_W-1:0] req_phase_b_i,
  input  logic signed [REQ_W-1:0] req_phase_c_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CMP_W-1:0]        out_phase_a_o,
  output logic [CMP_W-1:0]        out_phase_b_o,
  output logic [CMP_W-1:0]        out_phase_c_o,
  output logic [IO_PHASES-1:0]    clamp_mask_o,
  output logic signed [REQ_W-1:0] peak_req_o,
  output logic signed [REQ_W-1:0] min_req_o,
  output logic [CMP_W-1:0]        peak_out_o,
  output logic [CMP_W-1:0]        min_out_o,
  output logic [CNT_W-1:0]        clamped_items_o,
  output logic [CNT_W-1:0]        clamps_a_o,
  output logic [CNT_W-1:0]        clamps_b_o,
  output logic [CNT_W-1:0]        clamps_c_o
);

  localparam int unsigned ACT = (PHASES < IO_PHASES) ? PHASES : IO_PHASES;

  logic [CMP_W-1:0]                reload_q;
  logic                            in_valid_q;
  logic [IO_PHASES-1:0][REQ_W-1:0] req_q;
  logic                            out_valid_q;
  pcc_phase_t [IO_PHASES-1:0]      out_res_q;
  pcc_stats_t                      out_stats_q;

  logic                            in_take;
  logic                            adv;
  logic                            out_free;
  logic [IO_PHASES-1:0]            phase_en;
  pcc_phase_t [IO_PHASES-1:0]      raw_res;
  pcc_phase_t [IO_PHASES-1:0]      res;
  pcc_stats_t                      stats;

  // ---- handshake ----
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // ---- config ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= RELOAD_RST;
    end else if (cfg_we_i) begin
      reload_q <= cfg_wdata_i;
    end
  end

  // ---- input register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= {req_phase_c_i, req_phase_b_i, req_phase_a_i};
    end
  end

  // ---- clamp lanes ----
  for (genvar g = 0; g < IO_PHASES; g++) begin : g_phase
    assign phase_en[g] = (g < ACT);

    pcc_clamp u_clamp (
      .req_i    (req_q[g]),
      .reload_i (reload_q),
      .res_o    (raw_res[g])
    );

    // phases beyond PHASES report zero and never clamp
    assign res[g] = phase_en[g] ? raw_res[g] : '0;
  end

  pcc_stats u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .phase_en_i (phase_en),
    .req_i      (req_q),
    .res_i      (res),
    .stats_o    (stats)
  );

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q   <= res;
      out_stats_q <= stats;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_phase_a_o   = out_res_q[0].applied;
  assign out_phase_b_o   = out_res_q[1].applied;
  assign out_phase_c_o   = out_res_q[2].applied;
  assign clamp_mask_o    = {out_res_q[2].clamped, out_res_q[1].clamped,
                            out_res_q[0].clamped};
  assign peak_req_o      = out_stats_q.peak_req;
  assign min_req_o       = out_stats_q.min_req;
  assign peak_out_o      = out_stats_q.peak_out;
  assign min_out_o       = out_stats_q.min_out;
  assign clamped_items_o = out_stats_q.clamped_items;
  assign clamps_a_o      = out_stats_q.clamps[0];
  assign clamps_b_o      = out_stats_q.clamps[1];
  assign clamps_c_o      = out_stats_q.clamps[2];

  // ---- assertions ----
  a_req_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_req_o <= peak_req_o))
    else $error("min_req above peak_req");

  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_out_o <= peak_out_o))
    else $error("min_out above peak_out");

  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (clamp_mask_o != '0)) |-> (clamped_items_o != '0))
    else $error("clamped beat with zero item count");

  a_phase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clamp_mask_o[0]) |-> (clamps_a_o != '0))
    else $error("phase a clamped with zero count");

endmodule

`default_nettype wire
